FILE: src/wacc_pkg.sv
// Shared constants, register codes and pipeline types for the Wegstein
// acceleration block. No dependencies; used by the top level and the
// checker.
package wacc_pkg;

  localparam int MAX_ELEMENTS_DEFAULT = 1024;

  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int EPS_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;
  localparam int ONE_Q     = 65536;

  // Derived arithmetic widths.
  localparam int DX_W  = DATA_W + 1;       // dx, dg
  localparam int DQ_W  = DATA_W + 2;       // dg - dx
  localparam int NUM_W = DX_W + FRAC_W;    // |dg| * 2^16
  localparam int SQ_W  = NUM_W + 1;        // signed quotient
  localparam int W_W   = DATA_W + 1;       // 1.0 - q
  localparam int P1_W  = 2 * DATA_W;
  localparam int P2_W  = W_W + DATA_W;
  localparam int SUM_W = P2_W + 1;
  localparam int FL_W  = SUM_W - FRAC_W;

  localparam logic signed [DATA_W-1:0] Q_MIN_RESET = -32'sd327680;
  localparam logic signed [DATA_W-1:0] Q_MAX_RESET = 32'sd0;
  localparam logic [EPS_W-1:0]         EPS_X_RESET = 31'd1;
  localparam logic [EPS_W-1:0]         EPS_S_RESET = 31'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Q_MIN = 2'd0,
    CFG_Q_MAX = 2'd1,
    CFG_EPS_X = 2'd2,
    CFG_EPS_S = 2'd3
  } cfg_reg_t;

  // Sideband that travels with an item from the divider input to the end.
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] g;
    logic                     last;
    logic                     skip;
    logic                     neg_s;
    logic                     neg_q;
  } div_tag_t;

endpackage

FILE: src/wacc_div.sv
// Pipelined restoring divider with two lanes sharing one numerator.
// One quotient bit per stage; carries a sideband tag. No package use.
module wacc_div #(
  parameter int NW  = 49,
  parameter int DSW = 33,
  parameter int DQW = 34,
  parameter int TW  = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [NW-1:0]  num,
  input  logic [DSW-1:0] den_s,
  input  logic [DQW-1:0] den_q,
  input  logic [TW-1:0]  tag_in,
  output logic           out_valid,
  output logic [NW-1:0]  quo_s,
  output logic [NW-1:0]  quo_q,
  output logic [TW-1:0]  tag_out
);

  logic           vld   [NW];
  logic [TW-1:0]  tag   [NW];
  logic [DSW-1:0] rem_s [NW];
  logic [DQW-1:0] rem_q [NW];
  logic [DSW-1:0] dsv   [NW];
  logic [DQW-1:0] dqv   [NW];
  logic [NW-1:0]  nq_s  [NW];
  logic [NW-1:0]  nq_q  [NW];

  logic           v_i   [NW];
  logic [TW-1:0]  t_i   [NW];
  logic [DSW-1:0] rs_i  [NW];
  logic [DQW-1:0] rq_i  [NW];
  logic [DSW-1:0] ds_i  [NW];
  logic [DQW-1:0] dq_i  [NW];
  logic [NW-1:0]  ns_i  [NW];
  logic [NW-1:0]  nqq_i [NW];
  logic [DSW:0]   try_s [NW];
  logic [DQW:0]   try_q [NW];
  logic           ge_s  [NW];
  logic           ge_q  [NW];

  // Each stage shifts the next numerator bit into the partial remainder and
  // subtracts the divisor when it fits.
  always_comb begin
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        v_i[k]   = in_valid;
        t_i[k]   = tag_in;
        rs_i[k]  = '0;
        rq_i[k]  = '0;
        ds_i[k]  = den_s;
        dq_i[k]  = den_q;
        ns_i[k]  = num;
        nqq_i[k] = num;
      end else begin
        v_i[k]   = vld[k-1];
        t_i[k]   = tag[k-1];
        rs_i[k]  = rem_s[k-1];
        rq_i[k]  = rem_q[k-1];
        ds_i[k]  = dsv[k-1];
        dq_i[k]  = dqv[k-1];
        ns_i[k]  = nq_s[k-1];
        nqq_i[k] = nq_q[k-1];
      end
      try_s[k] = {rs_i[k], ns_i[k][NW-1]};
      try_q[k] = {rq_i[k], nqq_i[k][NW-1]};
      ge_s[k]  = try_s[k] >= {1'b0, ds_i[k]};
      ge_q[k]  = try_q[k] >= {1'b0, dq_i[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      tag[k]   <= t_i[k];
      dsv[k]   <= ds_i[k];
      dqv[k]   <= dq_i[k];
      rem_s[k] <= ge_s[k] ? DSW'(try_s[k] - {1'b0, ds_i[k]}) : try_s[k][DSW-1:0];
      rem_q[k] <= ge_q[k] ? DQW'(try_q[k] - {1'b0, dq_i[k]}) : try_q[k][DQW-1:0];
      nq_s[k]  <= {ns_i[k][NW-2:0], ge_s[k]};
      nq_q[k]  <= {nqq_i[k][NW-2:0], ge_q[k]};
    end
  end

  assign out_valid = vld[NW-1];
  assign quo_s     = nq_s[NW-1];
  assign quo_q     = nq_q[NW-1];
  assign tag_out   = tag[NW-1];

endmodule

FILE: src/wegstein_acceleration_step.sv
// Bounded Wegstein acceleration, one vector element per item.
// Depends on wacc_pkg and wacc_div.
//
// The block accepts one item per clock cycle while fewer than 64 items are
// pending, and returns one result per item in the order the items arrived.
// Most of an item's path from the accepting edge to the output register is
// the 49-stage bit-serial divider pipeline that forms the slope and the
// factor q.
// Per-element history (previous x and g) lives in a synchronous memory of
// MAX_ELEMENTS entries read when an item is accepted and written back in the
// next cycle; an item that follows its own element in the very next cycle
// takes the history from a bypass register. There is no clearing pass after
// reset. Results collect in a 64-entry output queue, and the input is only
// stalled when 64 items are in flight or waiting, so a slow consumer does not
// block the input until the queue is full. Configuration is written through a
// separate port that is always ready and must only be used while idle.
module wegstein_acceleration_step
  import wacc_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] x_value,
  input  logic signed [DATA_W-1:0] g_value,
  input  logic                     last_element,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         element_index_out,
  output logic signed [DATA_W-1:0] x_next,
  output logic signed [DATA_W-1:0] q_used,
  output logic                     last_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int AW     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int LAT    = NUM_W + 8;
  localparam int FDEPTH = 2 ** $clog2(LAT + 4);
  localparam int FAW    = $clog2(FDEPTH);
  localparam int PW     = FAW + 1;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] xn;
    logic signed [DATA_W-1:0] q;
    logic                     last;
  } res_t;

  // Element index to history slot, modulo the store depth. Indices are
  // narrow, so the reduction is a short chain of compare and subtract.
  function automatic logic [AW-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    r = idx;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (longint'(r) >= (longint'(MAX_ELEMENTS) << k)) begin
        r = r - IDX_W'(longint'(MAX_ELEMENTS) << k);
      end
    end
    return AW'(r);
  endfunction

  // Configuration registers.
  logic signed [DATA_W-1:0] q_min;
  logic signed [DATA_W-1:0] q_max;
  logic [EPS_W-1:0]         eps_x;
  logic [EPS_W-1:0]         eps_s;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_min <= Q_MIN_RESET;
      q_max <= Q_MAX_RESET;
      eps_x <= EPS_X_RESET;
      eps_s <= EPS_S_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_Q_MIN: q_min <= cfg_data;
        CFG_Q_MAX: q_max <= cfg_data;
        CFG_EPS_X: eps_x <= cfg_data[EPS_W-1:0];
        CFG_EPS_S: eps_s <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input acceptance and the first-vector flag. An item passes g through
  // when it belongs to the first vector after reset or to a restarted one;
  // the flag lasts until the last element of that vector.
  logic          in_acc;
  logic [AW-1:0] in_slot;
  logic          first_pass;
  logic [PW-1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign in_slot = slot_of(element_index);
  assign in_ready = pending < PW'(FDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pass <= 1'b1;
    end else if (in_acc) begin
      first_pass <= last_element ? 1'b0 : (first_pass || restart);
    end
  end

  // History memory: {prev_x, prev_g} per slot. Read on acceptance, written
  // back by the same item in the next cycle.
  logic [2*DATA_W-1:0] hist_mem [MAX_ELEMENTS];
  logic [2*DATA_W-1:0] hist_rd;

  logic                     s1_valid;
  logic [IDX_W-1:0]         s1_idx;
  logic signed [DATA_W-1:0] s1_x;
  logic signed [DATA_W-1:0] s1_g;
  logic                     s1_last;
  logic                     s1_pass;
  logic [AW-1:0]            s1_slot;
  logic                     s1_hit;
  logic [2*DATA_W-1:0]      s1_byp;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist_rd <= hist_mem[in_slot];
    end
    if (s1_valid) begin
      hist_mem[s1_slot] <= {s1_x, s1_g};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  // The write of the item ahead lands on the same edge as this read, so a
  // back-to-back item of the same slot takes that item's values directly.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx  <= element_index;
      s1_x    <= x_value;
      s1_g    <= g_value;
      s1_last <= last_element;
      s1_pass <= first_pass || restart;
      s1_slot <= in_slot;
      s1_hit  <= s1_valid && (s1_slot == in_slot);
      s1_byp  <= {s1_x, s1_g};
    end
  end

  // Differences against the history.
  logic [2*DATA_W-1:0]    prev_xg;
  logic signed [DX_W-1:0] dx1;
  logic signed [DX_W-1:0] dg1;

  assign prev_xg = s1_hit ? s1_byp : hist_rd;
  assign dx1 = DX_W'(s1_x) - DX_W'($signed(prev_xg[2*DATA_W-1:DATA_W]));
  assign dg1 = DX_W'(s1_g) - DX_W'($signed(prev_xg[DATA_W-1:0]));

  logic                     s2_valid;
  logic [IDX_W-1:0]         s2_idx;
  logic signed [DATA_W-1:0] s2_x;
  logic signed [DATA_W-1:0] s2_g;
  logic                     s2_last;
  logic                     s2_pass;
  logic signed [DX_W-1:0]   s2_dx;
  logic signed [DX_W-1:0]   s2_dg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx  <= s1_idx;
    s2_x    <= s1_x;
    s2_g    <= s1_g;
    s2_last <= s1_last;
    s2_pass <= s1_pass;
    s2_dx   <= dx1;
    s2_dg   <= dg1;
  end

  // Skip tests and divider operands. Both quotients share the numerator
  // dg * 2^16; the slope divides by dx and the factor by dg - dx.
  logic [DX_W-1:0]        abs_dx;
  logic [DX_W-1:0]        abs_dg;
  logic signed [DQ_W-1:0] dq2;
  logic [DQ_W-1:0]        abs_dq;
  logic                   skip2;
  div_tag_t               tag2;

  assign abs_dx = s2_dx[DX_W-1] ? DX_W'(-s2_dx) : DX_W'(s2_dx);
  assign abs_dg = s2_dg[DX_W-1] ? DX_W'(-s2_dg) : DX_W'(s2_dg);
  assign dq2    = DQ_W'(s2_dg) - DQ_W'(s2_dx);
  assign abs_dq = dq2[DQ_W-1] ? DQ_W'(-dq2) : DQ_W'(dq2);
  assign skip2  = s2_pass || (s2_dx == '0) || (abs_dx < DX_W'(eps_x)) || (s2_dg == s2_dx);

  always_comb begin
    tag2.idx   = s2_idx;
    tag2.x     = s2_x;
    tag2.g     = s2_g;
    tag2.last  = s2_last;
    tag2.skip  = skip2;
    tag2.neg_s = s2_dg[DX_W-1] ^ s2_dx[DX_W-1];
    tag2.neg_q = s2_dg[DX_W-1] ^ dq2[DQ_W-1];
  end

  logic             s3_valid;
  div_tag_t         s3_tag;
  logic [NUM_W-1:0] s3_num;
  logic [DX_W-1:0]  s3_den_s;
  logic [DQ_W-1:0]  s3_den_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_tag   <= tag2;
    s3_num   <= {abs_dg, {FRAC_W{1'b0}}};
    s3_den_s <= abs_dx;
    s3_den_q <= abs_dq;
  end

  // Magnitude division, one quotient bit per stage.
  logic                    dv_valid;
  logic [NUM_W-1:0]        dv_quo_s;
  logic [NUM_W-1:0]        dv_quo_q;
  logic [$bits(div_tag_t)-1:0] dv_tag_bits;
  div_tag_t                dv_tag;

  wacc_div #(
    .NW  (NUM_W),
    .DSW (DX_W),
    .DQW (DQ_W),
    .TW  ($bits(div_tag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .num       (s3_num),
    .den_s     (s3_den_s),
    .den_q     (s3_den_q),
    .tag_in    (s3_tag),
    .out_valid (dv_valid),
    .quo_s     (dv_quo_s),
    .quo_q     (dv_quo_q),
    .tag_out   (dv_tag_bits)
  );

  assign dv_tag = div_tag_t'(dv_tag_bits);

  // Restore the signs; truncation toward zero falls out of dividing
  // magnitudes.
  logic signed [SQ_W-1:0] s_mag;
  logic signed [SQ_W-1:0] q_mag;

  assign s_mag = $signed({1'b0, dv_quo_s});
  assign q_mag = $signed({1'b0, dv_quo_q});

  logic                   a_valid;
  div_tag_t               a_tag;
  logic signed [SQ_W-1:0] a_s;
  logic signed [SQ_W-1:0] a_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_tag <= dv_tag;
    a_s   <= dv_tag.neg_s ? -s_mag : s_mag;
    a_q   <= dv_tag.neg_q ? -q_mag : q_mag;
  end

  // Distance of the slope from one, and the lower clamp on q.
  logic signed [SQ_W:0] s_dev;

  assign s_dev = (SQ_W+1)'(a_s) - (SQ_W+1)'(ONE_Q);

  logic                   b_valid;
  div_tag_t               b_tag;
  logic [SQ_W:0]          b_dev;
  logic signed [SQ_W-1:0] b_qlo;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_tag <= a_tag;
    b_dev <= s_dev[SQ_W] ? (SQ_W+1)'(-s_dev) : (SQ_W+1)'(s_dev);
    b_qlo <= (a_q < SQ_W'(q_min)) ? SQ_W'(q_min) : a_q;
  end

  // Upper clamp; with crossed limits this yields q_max as intended. The
  // clamped value always fits 32 bits.
  logic                     zero_q;
  logic signed [SQ_W-1:0]   q_hi;
  logic signed [DATA_W-1:0] q32;

  assign zero_q = b_tag.skip || (b_dev < (SQ_W+1)'(eps_s));
  assign q_hi   = (b_qlo > SQ_W'(q_max)) ? SQ_W'(q_max) : b_qlo;
  assign q32    = zero_q ? '0 : DATA_W'(q_hi);

  logic                     c_valid;
  div_tag_t                 c_tag;
  logic signed [DATA_W-1:0] c_q;
  logic signed [W_W-1:0]    c_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_tag <= b_tag;
    c_q   <= q32;
    c_w   <= W_W'(ONE_Q) - W_W'(q32);
  end

  // q*x and (1-q)*g in Q32.32.
  logic                   d_valid;
  div_tag_t               d_tag;
  logic signed [DATA_W-1:0] d_q;
  logic signed [P1_W-1:0] d_p1;
  logic signed [P2_W-1:0] d_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_tag <= c_tag;
    d_q   <= c_q;
    d_p1  <= c_q * $signed(c_tag.x);
    d_p2  <= c_w * $signed(c_tag.g);
  end

  // Exact sum, floor back to Q16.16 by arithmetic shift, then saturate.
  logic signed [SUM_W-1:0] sum_e;
  logic signed [FL_W-1:0]  fl_e;
  logic                    pos_ovf;
  logic                    neg_ovf;
  logic signed [DATA_W-1:0] xn_e;

  assign sum_e   = SUM_W'(d_p1) + SUM_W'(d_p2);
  assign fl_e    = sum_e[SUM_W-1:FRAC_W];
  assign pos_ovf = !fl_e[FL_W-1] && (|fl_e[FL_W-2:DATA_W-1]);
  assign neg_ovf = fl_e[FL_W-1] && !(&fl_e[FL_W-2:DATA_W-1]);

  always_comb begin
    if (pos_ovf) begin
      xn_e = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg_ovf) begin
      xn_e = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      xn_e = fl_e[DATA_W-1:0];
    end
  end

  logic e_valid;
  res_t e_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_res.idx  <= d_tag.idx;
    e_res.xn   <= xn_e;
    e_res.q    <= d_q;
    e_res.last <= d_tag.last;
  end

  // Output queue. Every accepted item holds a place until it leaves the
  // queue, so the pipeline never has to stall.
  res_t           fifo_mem [FDEPTH];
  logic [FAW-1:0] wptr;
  logic [FAW-1:0] rptr;
  logic [PW-1:0]  fcount;
  logic           fifo_rd;

  assign fifo_rd = (fcount != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (e_valid) begin
      fifo_mem[wptr] <= e_res;
    end
    if (fifo_rd) begin
      {element_index_out, x_next, q_used, last_out} <= fifo_mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      fcount    <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (e_valid) begin
        wptr <= wptr + FAW'(1);
      end
      if (fifo_rd) begin
        rptr <= rptr + FAW'(1);
      end
      fcount  <= fcount + PW'(e_valid) - PW'(fifo_rd);
      pending <= pending + PW'(in_acc) - PW'(fifo_rd);
      if (fifo_rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/wacc_checker.sv
// Port-level checker for the Wegstein acceleration block and its bind.
// Depends on wacc_pkg.
module wacc_props
  import wacc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [IDX_W-1:0]         element_index_out,
  input logic signed [DATA_W-1:0] x_next,
  input logic signed [DATA_W-1:0] q_used,
  input logic                     last_out,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic [DATA_W-1:0]        cfg_data
);

  logic [15:0]              outstanding;
  logic                     first_vec;
  logic signed [DATA_W-1:0] q_min_sh;
  logic signed [DATA_W-1:0] q_max_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      first_vec   <= 1'b1;
      q_min_sh    <= Q_MIN_RESET;
      q_max_sh    <= Q_MAX_RESET;
    end else begin
      outstanding <= outstanding + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
      if (out_valid && out_ready && last_out) begin
        first_vec <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_Q_MIN: q_min_sh <= cfg_data;
          CFG_Q_MAX: q_max_sh <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // A waiting result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_next) && $stable(q_used)
      && $stable(element_index_out) && $stable(last_out))
    else $error("result changed while stalled");

  // Every result belongs to an accepted item.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 16'd0)
    else $error("result without an accepted item");

  // The input only stalls when work is in flight.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> outstanding != 16'd0)
    else $error("input stalled while idle");

  // The first vector after reset is passed through.
  a_first_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_vec |-> q_used == '0)
    else $error("acceleration applied on first vector");

  // The factor respects the clamps.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (q_used == '0) || ((q_used <= q_max_sh)
      && ((q_used >= q_min_sh) || (q_min_sh > q_max_sh))))
    else $error("factor outside clamp range");

endmodule

bind wegstein_acceleration_step wacc_props u_wacc_props (.*);
